@@ design/leaky_bucket_policer_core_assert.svh @@
// Assertion macros for the leaky bucket policer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LEAKY_BUCKET_POLICER_CORE_ASSERT_SVH
`define LEAKY_BUCKET_POLICER_CORE_ASSERT_SVH

// same-cycle implication
`define LBP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LBP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lbp_pkg.sv @@
// Shared types and constants for the leaky bucket policer.
// No dependencies; used by lbp_div and leaky_bucket_policer_core.
package lbp_pkg;

  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned WAIT_W   = 26;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned PROD_W   = 2 * UNIT_W;

  localparam logic [UNIT_W-1:0] MS_PER_TICK   = UNIT_W'(1000);
  localparam logic [UNIT_W-1:0] CAP_RST       = UNIT_W'(100);
  localparam logic [UNIT_W-1:0] RATE_RST      = UNIT_W'(10);
  localparam logic [UNIT_W-1:0] INIT_WATER_RST = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE       = 3'd0,
    CMD_CONSUME      = 3'd1,
    CMD_CONSUME_WAIT = 3'd2,
    CMD_CHECK        = 3'd3,
    CMD_RESET        = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY   = 2'd0,
    CFG_DRAIN_RATE = 2'd1,
    CFG_INIT_WATER = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_APPLY,
    ST_WMUL,
    ST_WSTART,
    ST_WWAIT,
    ST_FSTART,
    ST_FWAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/lbp_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, 32 steps.
// Depends on lbp_pkg for widths and the status struct.
module lbp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lbp_pkg::DIV_W-1:0]      dividend_i,
  input  logic [lbp_pkg::UNIT_W-1:0]     divisor_i,
  output logic [lbp_pkg::DIV_W-1:0]      quotient_o,
  output lbp_pkg::div_stat_t             stat_o
);

  logic [lbp_pkg::UNIT_W-1:0]    rem_q, rem_d;
  logic [lbp_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [lbp_pkg::UNIT_W-1:0]    dvs_q;
  logic [lbp_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [lbp_pkg::UNIT_W:0]      rem_sh, rem_sub;
  logic                          fits;

  // partial remainder stays below the divisor, so 16 bits hold it
  always_comb begin
    rem_sh  = {rem_q, quo_q[lbp_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_d   = fits ? rem_sub[lbp_pkg::UNIT_W-1:0] : rem_sh[lbp_pkg::UNIT_W-1:0];
    quo_d   = {quo_q[lbp_pkg::DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ design/leaky_bucket_policer_core.sv @@
// Leaky bucket policer: sequencer, shared 16x16 multiplier and one shared divider.
// Depends on lbp_pkg and lbp_div.
//
// Usage
//  - Input request (cmd, elapsed_ticks, amount, wait limit) is taken on
//    in_valid_i && in_ready_o. One request is handled at a time; in_ready_o is
//    high only while the block is idle.
//  - Result goes out on out_valid_o / out_ready_i and is held in output
//    registers until taken; a stalled receiver simply keeps the block busy.
//  - The radix-2 divider is reused for the wait (overflow * 1000 / rate) and the
//    fill fraction, 32 steps each. The wait is divided only for a consume-with-wait
//    or check that does not fit while the rate is nonzero; the fill division is
//    skipped when capacity is zero.
//  - The drain (ticks * rate) and overflow * 1000 share one registered
//    multiplier.
//  - Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 capacity,
//    1 drain rate, 2 initial water). The user must write only while idle; not enforced.
//  - Reset: capacity 100, rate 10, initial water 0, bucket empty.
module leaky_bucket_policer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lbp_pkg::UNIT_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lbp_pkg::CMD_W-1:0]         cmd_i,
  input  logic [lbp_pkg::UNIT_W-1:0]        elapsed_ticks_i,
  input  logic [lbp_pkg::UNIT_W-1:0]        amount_i,
  input  logic [lbp_pkg::WAIT_W-1:0]        wait_limit_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              granted_o,
  output logic                              status_o,
  output logic [lbp_pkg::WAIT_W-1:0]        wait_ms_o,
  output logic                              wait_too_long_o,
  output logic [lbp_pkg::UNIT_W-1:0]        water_level_o,
  output logic [lbp_pkg::UNIT_W-1:0]        available_room_o,
  output logic                              is_full_o,
  output logic                              bucket_empty_o,
  output logic [lbp_pkg::FRAC_W-1:0]        fill_fraction_o
);

  lbp_pkg::state_e state_q, state_d;

  logic [lbp_pkg::UNIT_W-1:0] cap_q, rate_q, init_q;
  logic [lbp_pkg::UNIT_W-1:0] water_q;

  lbp_pkg::cmd_e              cmd_q;
  logic [lbp_pkg::UNIT_W-1:0] ticks_q, amt_q, need_q;
  logic [lbp_pkg::WAIT_W-1:0] max_wait_q;
  logic [lbp_pkg::PROD_W-1:0] prod_q;

  logic                       granted_q, status_q, too_long_q;
  logic [lbp_pkg::WAIT_W-1:0] wait_q;
  logic [lbp_pkg::FRAC_W-1:0] fill_q;

  // sequencer outputs
  logic mul_en, mul_sel_need, div_start, div_sel_fill;

  logic [lbp_pkg::UNIT_W-1:0] mul_a, mul_b;
  logic [lbp_pkg::DIV_W-1:0]  div_dividend, div_quo;
  logic [lbp_pkg::UNIT_W-1:0] div_divisor;
  lbp_pkg::div_stat_t         div_stat;

  // apply-stage datapath
  logic [lbp_pkg::UNIT_W-1:0] w_drained, w_clamped, init_clamped, w_new;
  logic [lbp_pkg::UNIT_W:0]   w_sum;
  logic                       is_use, too_big, fits, need_wait;
  logic [lbp_pkg::WAIT_W-1:0] wait_t;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= lbp_pkg::CAP_RST;
      rate_q <= lbp_pkg::RATE_RST;
      init_q <= lbp_pkg::INIT_WATER_RST;
    end else if (cfg_we_i) begin
      case (lbp_pkg::cfg_idx_e'(cfg_idx_i))
        lbp_pkg::CFG_CAPACITY:   cap_q  <= cfg_wdata_i;
        lbp_pkg::CFG_DRAIN_RATE: rate_q <= cfg_wdata_i;
        lbp_pkg::CFG_INIT_WATER: init_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbp_pkg::ST_IDLE:   if (in_valid_i) state_d = lbp_pkg::ST_DRAIN;
      lbp_pkg::ST_DRAIN:  state_d = lbp_pkg::ST_APPLY;
      lbp_pkg::ST_APPLY:  state_d = (need_wait && rate_q != '0) ? lbp_pkg::ST_WMUL
                                                                : lbp_pkg::ST_FSTART;
      lbp_pkg::ST_WMUL:   state_d = lbp_pkg::ST_WSTART;
      lbp_pkg::ST_WSTART: state_d = lbp_pkg::ST_WWAIT;
      lbp_pkg::ST_WWAIT:  if (div_stat.done) state_d = lbp_pkg::ST_FSTART;
      lbp_pkg::ST_FSTART: state_d = (cap_q == '0) ? lbp_pkg::ST_RESP : lbp_pkg::ST_FWAIT;
      lbp_pkg::ST_FWAIT:  if (div_stat.done) state_d = lbp_pkg::ST_RESP;
      lbp_pkg::ST_RESP:   if (out_ready_i) state_d = lbp_pkg::ST_IDLE;
      default:            state_d = lbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    mul_en       = 1'b0;
    mul_sel_need = 1'b0;
    div_start    = 1'b0;
    div_sel_fill = 1'b0;
    case (state_q)
      lbp_pkg::ST_IDLE:   in_ready_o = 1'b1;
      lbp_pkg::ST_DRAIN:  mul_en = 1'b1;
      lbp_pkg::ST_WMUL: begin
        mul_en       = 1'b1;
        mul_sel_need = 1'b1;
      end
      lbp_pkg::ST_WSTART: div_start = 1'b1;
      lbp_pkg::ST_FSTART: begin
        div_start    = (cap_q != '0);
        div_sel_fill = 1'b1;
      end
      lbp_pkg::ST_RESP:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- shared multiplier ----------------
  assign mul_a = mul_sel_need ? need_q : ticks_q;
  assign mul_b = mul_sel_need ? lbp_pkg::MS_PER_TICK : rate_q;

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= {{lbp_pkg::UNIT_W{1'b0}}, mul_a} * {{lbp_pkg::UNIT_W{1'b0}}, mul_b};
    end
  end

  // ---------------- shared divider ----------------
  assign div_dividend = div_sel_fill ? {water_q, {lbp_pkg::UNIT_W{1'b0}}}
                                     : {{(lbp_pkg::DIV_W-lbp_pkg::WAIT_W){1'b0}},
                                        prod_q[lbp_pkg::WAIT_W-1:0]};
  assign div_divisor  = div_sel_fill ? cap_q : rate_q;

  lbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign wait_t = div_quo[lbp_pkg::WAIT_W-1:0];

  // ---------------- drain and command ----------------
  always_comb begin
    w_drained    = ({{lbp_pkg::UNIT_W{1'b0}}, water_q} > prod_q)
                 ? water_q - prod_q[lbp_pkg::UNIT_W-1:0] : '0;
    w_clamped    = (w_drained > cap_q) ? cap_q : w_drained;
    init_clamped = (init_q > cap_q) ? cap_q : init_q;
    w_sum        = {1'b0, w_clamped} + {1'b0, amt_q};
    is_use       = (cmd_q == lbp_pkg::CMD_CONSUME) || (cmd_q == lbp_pkg::CMD_CONSUME_WAIT)
                || (cmd_q == lbp_pkg::CMD_CHECK);
    too_big      = (amt_q > cap_q);
    fits         = (w_sum <= {1'b0, cap_q});
    need_wait    = is_use && !too_big && !fits && (cmd_q != lbp_pkg::CMD_CONSUME);
    w_new        = w_clamped;
    if (cmd_q == lbp_pkg::CMD_RESET) begin
      w_new = init_clamped;
    end else if (is_use && !too_big && fits && cmd_q != lbp_pkg::CMD_CHECK) begin
      w_new = w_sum[lbp_pkg::UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_q <= lbp_pkg::INIT_WATER_RST;
    end else if (state_q == lbp_pkg::ST_APPLY) begin
      water_q <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lbp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_q      <= lbp_pkg::cmd_e'(cmd_i);
          ticks_q    <= elapsed_ticks_i;
          amt_q      <= amount_i;
          max_wait_q <= wait_limit_i;
        end
      end
      lbp_pkg::ST_APPLY: begin
        granted_q  <= is_use && !too_big && fits;
        status_q   <= is_use && too_big;
        wait_q     <= '0;
        too_long_q <= 1'b0;
        need_q     <= w_sum[lbp_pkg::UNIT_W-1:0] - cap_q;
        // zero rate: the wait is unbounded
        if (need_wait && rate_q == '0) begin
          if (cmd_q == lbp_pkg::CMD_CONSUME_WAIT) begin
            too_long_q <= 1'b1;
          end else begin
            wait_q <= '1;
          end
        end
      end
      lbp_pkg::ST_WWAIT: begin
        if (div_stat.done) begin
          if (cmd_q != lbp_pkg::CMD_CONSUME_WAIT) begin
            wait_q <= wait_t;
          end else if (wait_t > max_wait_q) begin
            too_long_q <= 1'b1;
          end else begin
            wait_q <= wait_t;
          end
        end
      end
      lbp_pkg::ST_FSTART: begin
        if (cap_q == '0) begin
          fill_q <= '0;
        end
      end
      lbp_pkg::ST_FWAIT: begin
        if (div_stat.done) begin
          fill_q <= div_quo[lbp_pkg::FRAC_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------- result ----------------
  assign granted_o        = granted_q;
  assign status_o         = status_q;
  assign wait_ms_o        = wait_q;
  assign wait_too_long_o  = too_long_q;
  assign water_level_o    = water_q;
  assign available_room_o = cap_q - water_q;
  assign is_full_o        = (water_q >= cap_q);
  assign bucket_empty_o   = (water_q == '0);
  assign fill_fraction_o  = fill_q;

endmodule

@@ design/lbp_checker.sv @@
// Port-level checks for leaky_bucket_policer_core, bound into that module.
// Depends on leaky_bucket_policer_core_assert.svh and lbp_pkg.
`include "leaky_bucket_policer_core_assert.svh"

module lbp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          granted_o,
  input logic                          status_o,
  input logic [lbp_pkg::WAIT_W-1:0]    wait_ms_o,
  input logic                          wait_too_long_o,
  input logic [lbp_pkg::UNIT_W-1:0]    water_level_o,
  input logic                          bucket_empty_o
);

  // one request in flight: never ready while a result is pending
  `LBP_ASSERT_NOW(a_one_in_flight, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready while result pending")

  `LBP_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o, "no busy phase after request")

  `LBP_ASSERT_NXT(a_result_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(water_level_o) && $stable(wait_ms_o), "stalled result changed")

  `LBP_ASSERT_NOW(a_grant_no_wait, clk_i, rst_ni, out_valid_o && granted_o, wait_ms_o == '0 && !status_o && !wait_too_long_o, "grant with wait or error")

  `LBP_ASSERT_NOW(a_too_long_no_wait, clk_i, rst_ni, out_valid_o && wait_too_long_o, wait_ms_o == '0 && (bucket_empty_o == (water_level_o == '0)), "too-long result carries a wait")

endmodule

bind leaky_bucket_policer_core lbp_checker u_lbp_checker (.*);

@@ verif/leaky_bucket_policer_core_tb.sv @@
// Testbench for leaky_bucket_policer_core: directed and random requests, in-line predictor.
// Depends on lbp_pkg and the policer RTL; scoreboard checks every result field.
module leaky_bucket_policer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbp_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_REQS   = 86;
  localparam int unsigned CMD_TOP      = (1 << CMD_W) - 1;
  localparam logic [UNIT_W-1:0] UNIT_MAX = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [UNIT_W-1:0] ticks;
    logic [UNIT_W-1:0] amount;
    logic [WAIT_W-1:0] max_wait;
  } police_req_t;

  typedef struct packed {
    logic              granted;
    logic              status;
    logic [WAIT_W-1:0] wait_ms;
    logic              too_long;
    logic [UNIT_W-1:0] level;
    logic [UNIT_W-1:0] room;
    logic              full;
    logic              empty;
    logic [FRAC_W-1:0] frac;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [UNIT_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd_i = '0;
  logic [UNIT_W-1:0] elapsed_ticks_i = '0;
  logic [UNIT_W-1:0] amount_i = '0;
  logic [WAIT_W-1:0] wait_limit_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              granted_o;
  logic              status_o;
  logic [WAIT_W-1:0] wait_ms_o;
  logic              wait_too_long_o;
  logic [UNIT_W-1:0] water_level_o;
  logic [UNIT_W-1:0] available_room_o;
  logic              is_full_o;
  logic              bucket_empty_o;
  logic [FRAC_W-1:0] fill_fraction_o;

  // predictor copy of the registers and the bucket
  logic [UNIT_W-1:0] cap_reg  = CAP_RST;
  logic [UNIT_W-1:0] rate_reg = RATE_RST;
  logic [UNIT_W-1:0] init_reg = INIT_WATER_RST;
  logic [UNIT_W-1:0] water_lvl = '0;

  police_req_t police_q[$];
  verdict_t    verdict_q[$];
  int unsigned err_cnt = 0;
  int unsigned req_cnt = 0;
  int unsigned rsp_cnt = 0;
  logic        idle_on = 1'b1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  leaky_bucket_policer_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .elapsed_ticks_i  (elapsed_ticks_i),
    .amount_i         (amount_i),
    .wait_limit_i     (wait_limit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_o        (granted_o),
    .status_o         (status_o),
    .wait_ms_o        (wait_ms_o),
    .wait_too_long_o  (wait_too_long_o),
    .water_level_o    (water_level_o),
    .available_room_o (available_room_o),
    .is_full_o        (is_full_o),
    .bucket_empty_o   (bucket_empty_o),
    .fill_fraction_o  (fill_fraction_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // drain, clamp, then apply the command; updates the bucket
  function automatic verdict_t police_req(input police_req_t r);
    verdict_t v;
    longint unsigned lvl, drain, need, t;
    v = '0;
    lvl = water_lvl;
    drain = 64'(r.ticks) * 64'(rate_reg);
    lvl = (lvl > drain) ? lvl - drain : 0;
    if (lvl > cap_reg) lvl = cap_reg;
    case (r.cmd)
      CMD_CONSUME, CMD_CONSUME_WAIT, CMD_CHECK: begin
        if (r.amount > cap_reg) begin
          v.status = 1'b1;
        end else if (lvl + r.amount <= cap_reg) begin
          v.granted = 1'b1;
          if (r.cmd != CMD_CHECK) lvl += r.amount;
        end else if (r.cmd != CMD_CONSUME) begin
          need = lvl + r.amount - cap_reg;
          t = (rate_reg == 0) ? 64'(WAIT_MAX) : need * MS_PER_TICK / rate_reg;
          if (r.cmd == CMD_CHECK) v.wait_ms = WAIT_W'(t);
          else if (rate_reg == 0 || t > r.max_wait) v.too_long = 1'b1;
          else v.wait_ms = WAIT_W'(t);
        end
      end
      CMD_RESET: lvl = (init_reg > cap_reg) ? cap_reg : init_reg;
      default: ;
    endcase
    water_lvl = UNIT_W'(lvl);
    v.level = UNIT_W'(lvl);
    v.room  = cap_reg - UNIT_W'(lvl);
    v.full  = (lvl >= cap_reg);
    v.empty = (lvl == 0);
    v.frac  = (cap_reg == 0) ? '0 : FRAC_W'((lvl << 16) / cap_reg);
    return v;
  endfunction

  // mostly back to back, some short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_fld(input string nm, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
      err_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    police_req_t nxt;
    logic vld;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {cmd_i, elapsed_ticks_i, amount_i, wait_limit_i} <= '0;
      gap_left = 0;
    end else begin
      nxt = {cmd_i, elapsed_ticks_i, amount_i, wait_limit_i};
      vld = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        verdict_q.push_back(police_req(nxt));
        vld = 1'b0;
        gap_left = pick_gap();
      end
      if (!vld) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (police_q.size() != 0) begin
          nxt = police_q.pop_front();
          vld = 1'b1;
        end
      end
      in_valid_i <= vld;
      {cmd_i, elapsed_ticks_i, amount_i, wait_limit_i} <= nxt;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        rsp_cnt++;
        if (verdict_q.size() == 0) begin
          $display("%0t ns: result with no request outstanding, water %0d", $time,
                   water_level_o);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          check_fld("granted", 32'(want.granted), 32'(granted_o));
          check_fld("status", 32'(want.status), 32'(status_o));
          check_fld("wait_ms", 32'(want.wait_ms), 32'(wait_ms_o));
          check_fld("wait_too_long", 32'(want.too_long), 32'(wait_too_long_o));
          check_fld("water_level", 32'(want.level), 32'(water_level_o));
          check_fld("available_room", 32'(want.room), 32'(available_room_o));
          check_fld("is_full", 32'(want.full), 32'(is_full_o));
          check_fld("bucket_empty", 32'(want.empty), 32'(bucket_empty_o));
          check_fld("fill_fraction", 32'(want.frac), 32'(fill_fraction_o));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [UNIT_W-1:0] ticks,
                          input logic [UNIT_W-1:0] amt, input logic [WAIT_W-1:0] maxw);
    police_q.push_back('{cmd, ticks, amt, maxw});
    req_cnt++;
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [UNIT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CAPACITY:   cap_reg  = val;
      CFG_DRAIN_RATE: rate_reg = val;
      default:        init_reg = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_bucket(input logic [UNIT_W-1:0] cap, input logic [UNIT_W-1:0] rate,
                            input logic [UNIT_W-1:0] init);
    write_cfg(CFG_CAPACITY, cap);
    write_cfg(CFG_DRAIN_RATE, rate);
    write_cfg(CFG_INIT_WATER, init);
  endtask

  // block is idle once every request has come back out
  task automatic wait_drained();
    while (rsp_cnt < req_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic police_req_t rand_req();
    police_req_t r;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 25)      r.cmd = CMD_CONSUME;
    else if (p < 50) r.cmd = CMD_CONSUME_WAIT;
    else if (p < 72) r.cmd = CMD_CHECK;
    else if (p < 84) r.cmd = CMD_UPDATE;
    else if (p < 92) r.cmd = CMD_RESET;
    else             r.cmd = CMD_W'($urandom_range(CMD_RESET + 1, CMD_TOP));
    // few ticks so the bucket actually fills up between drains
    p = $urandom_range(0, 99);
    if (p < 65)      r.ticks = '0;
    else if (p < 90) r.ticks = UNIT_W'($urandom_range(1, 2));
    else             r.ticks = UNIT_W'($urandom());
    p = $urandom_range(0, 99);
    if (p < 75)      r.amount = UNIT_W'($urandom_range(0, cap_reg));
    else if (p < 88) r.amount = (cap_reg == UNIT_MAX) ? UNIT_MAX
                                : UNIT_W'($urandom_range(cap_reg + 1, UNIT_MAX));
    else             r.amount = UNIT_W'($urandom());
    p = $urandom_range(0, 2);
    if (p == 0)      r.max_wait = WAIT_W'($urandom());
    else if (p == 1) r.max_wait = WAIT_W'($urandom_range(0, 20000));
    else             r.max_wait = WAIT_W'($urandom_range(0, 1 << 20));
    return r;
  endfunction

  initial begin
    logic [UNIT_W-1:0] cap, rate, init;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: capacity 100, rate 10
    push_req(CMD_UPDATE, 0, 0, 0);
    push_req(CMD_CONSUME, 0, 40, 0);
    push_req(CMD_CONSUME, 0, 70, 0);              // does not fit, no wait reported
    push_req(CMD_CHECK, 0, 70, 0);                // check reports the wait
    push_req(CMD_CONSUME_WAIT, 0, 70, 999);       // wait just over the limit
    push_req(CMD_CONSUME_WAIT, 0, 70, 1000);      // wait exactly at the limit
    push_req(CMD_CONSUME, 0, 101, 0);             // amount above capacity
    push_req(CMD_CONSUME_WAIT, 0, 60, WAIT_MAX);  // fills to the brim
    push_req(CMD_CHECK, 0, 0, 0);
    push_req(CMD_UPDATE, UNIT_MAX, 0, 0);
    for (int c = CMD_RESET + 1; c <= CMD_TOP; c++) push_req(CMD_W'(c), 1, 50, WAIT_MAX);
    push_req(CMD_RESET, 0, 0, 0);
    wait_drained();

    set_bucket(UNIT_MAX, 1, UNIT_MAX);
    push_req(CMD_RESET, 0, 0, 0);
    push_req(CMD_CHECK, 0, UNIT_MAX, WAIT_MAX);         // largest wait
    push_req(CMD_CONSUME_WAIT, 0, UNIT_MAX, WAIT_MAX);
    push_req(CMD_CONSUME_WAIT, 0, 1, 0);
    push_req(CMD_UPDATE, UNIT_MAX, 0, 0);
    push_req(CMD_CONSUME, 0, UNIT_MAX, 0);
    wait_drained();

    // capacity lowered under a full bucket
    write_cfg(CFG_CAPACITY, 50);
    push_req(CMD_UPDATE, 0, 0, 0);
    wait_drained();

    // zero drain rate: infinite wait
    write_cfg(CFG_DRAIN_RATE, 0);
    push_req(CMD_CHECK, 0, 10, 0);
    push_req(CMD_CONSUME_WAIT, 0, 10, WAIT_MAX);
    push_req(CMD_UPDATE, UNIT_MAX, 0, 0);
    wait_drained();

    // zero capacity
    set_bucket(0, 3, 7);
    push_req(CMD_UPDATE, 0, 0, 0);
    push_req(CMD_CONSUME, 0, 0, 0);
    push_req(CMD_CONSUME_WAIT, 0, 1, 0);
    push_req(CMD_RESET, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin cap = UNIT_MAX; rate = 1;        init = UNIT_MAX; end
        1: begin cap = 1;        rate = UNIT_MAX; init = UNIT_MAX; end
        default: begin
          case ($urandom_range(0, 4))
            0:       cap = UNIT_MAX;
            1:       cap = UNIT_W'($urandom_range(1, 16));
            default: cap = UNIT_W'($urandom_range(1, UNIT_MAX));
          endcase
          case ($urandom_range(0, 7))
            0:       rate = 0;
            1:       rate = UNIT_MAX;
            2:       rate = 1;
            3:       rate = UNIT_W'($urandom());
            default: rate = UNIT_W'($urandom_range(1, cap / 8 + 1));
          endcase
          init = ($urandom_range(0, 3) == 0) ? UNIT_W'($urandom())
                                             : UNIT_W'($urandom_range(0, cap));
        end
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      set_bucket(cap, rate, init);
      for (int i = 0; i < PHASE_REQS; i++) begin
        police_q.push_back(rand_req());
        req_cnt++;
      end
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t ns: run timed out", $time);
    $display("Verification failed");
    $finish;
  end

endmodule
